// ===== design/topc_pkg.sv =====
// Shared types and constants for the top-off pump controller.
`default_nettype none

package topc_pkg;

	// Width of the run timer and of its timeout register.
	localparam int unsigned TimerW = 16;

	// Timeout value after reset, in one-second ticks.
	localparam logic [TimerW-1:0] TimeoutReset = TimerW'(60);

	// Kind of input transaction.
	typedef enum logic [1:0] {
		OP_POLL  = 2'd0,
		OP_TICK  = 2'd1,
		OP_FORCE = 2'd2,
		OP_NONE  = 2'd3
	} op_e_t;

	// Controller mode; the codes are the reported mode values.
	typedef enum logic [2:0] {
		MODE_ON      = 3'd0,
		MODE_WORKING = 3'd1,
		MODE_OFF     = 3'd2,
		MODE_FORCE   = 3'd3,
		MODE_FORCED  = 3'd4,
		MODE_ALARM   = 3'd5,
		MODE_ERROR   = 3'd6,
		MODE_UNUSED  = 3'd7
	} mode_e_t;

	// Input transaction payload.
	typedef struct packed {
		logic [1:0] operation;
		logic       tank_level_ok;
		logic       reserve_low_ok;
		logic       reserve_high_ok;
		logic       force_on;
	} in_item_t;

	// Result transaction payload.
	typedef struct packed {
		logic       tank_pump_on;
		logic       reserve_valve_on;
		logic       alarm;
		logic [2:0] mode;
	} out_item_t;

	// Controller state carried from one transaction to the next.
	typedef struct packed {
		mode_e_t           mode;
		logic [TimerW-1:0] timer_left;
		logic              timer_running;
		logic              fill_pump;
		logic              refill_valve;
		logic              alarm;
	} ctrl_state_t;

endpackage : topc_pkg

`default_nettype wire

// ===== design/topc_next.sv =====
// Next-state logic of the top-off pump controller for one input transaction.
`default_nettype none

module topc_next
	import topc_pkg::*;
(
	input  ctrl_state_t       cur,
	input  in_item_t          item,
	input  logic [TimerW-1:0] timeout,
	output ctrl_state_t       nxt
);

	// Apply one poll, tick or force command to the current state.
	always_comb begin
		nxt = cur;
		case (op_e_t'(item.operation))
			OP_POLL: begin
				if (cur.mode == MODE_ERROR) begin
					// Contradicting reserve contacts were seen: shut everything down.
					nxt.timer_running = 1'b0;
					nxt.timer_left    = '0;
					nxt.fill_pump     = 1'b0;
					nxt.refill_valve  = 1'b0;
					nxt.alarm         = 1'b1;
					nxt.mode          = MODE_ALARM;
				end else if (cur.mode == MODE_FORCE) begin
					// Start the forced hold and clear the alarm.
					nxt.timer_left    = timeout;
					nxt.timer_running = 1'b1;
					nxt.mode          = MODE_FORCED;
					nxt.alarm         = 1'b0;
				end else if (cur.mode != MODE_ALARM && !item.reserve_low_ok &&
						!item.reserve_high_ok) begin
					nxt.mode = MODE_ERROR;
				end else begin
					// Reserve ran dry: stop pumping and refill the reserve.
					if ((nxt.mode == MODE_ON || nxt.mode == MODE_WORKING ||
							nxt.mode == MODE_FORCED) && !item.reserve_low_ok) begin
						nxt.timer_running = 1'b0;
						nxt.timer_left    = '0;
						nxt.fill_pump     = 1'b0;
						nxt.refill_valve  = 1'b1;
						nxt.mode          = MODE_OFF;
					end
					// Reserve is full: close the refill valve and return from off to on.
					if (!item.reserve_high_ok) begin
						if (nxt.mode == MODE_OFF) begin
							nxt.mode = MODE_ON;
						end
						nxt.refill_valve = 1'b0;
					end
					if (nxt.mode == MODE_OFF && item.reserve_low_ok) begin
						nxt.mode = MODE_ON;
					end
					// Tank level low: start the pump and the run timer.
					if (nxt.mode == MODE_ON && !item.tank_level_ok) begin
						nxt.fill_pump     = 1'b1;
						nxt.timer_left    = timeout;
						nxt.timer_running = 1'b1;
						nxt.mode          = MODE_WORKING;
					end
					// Tank level reached: stop the pump.
					if (nxt.mode == MODE_WORKING && item.tank_level_ok) begin
						nxt.timer_running = 1'b0;
						nxt.timer_left    = '0;
						nxt.mode          = MODE_ON;
						nxt.fill_pump     = 1'b0;
					end
				end
			end
			OP_TICK: begin
				// Count the run timer down; expiry ends a forced hold or raises the alarm.
				if (cur.timer_running) begin
					if (cur.timer_left > TimerW'(1)) begin
						nxt.timer_left = cur.timer_left - TimerW'(1);
					end else begin
						nxt.timer_running = 1'b0;
						nxt.timer_left    = '0;
						nxt.fill_pump     = 1'b0;
						if (cur.mode == MODE_FORCED) begin
							nxt.mode = MODE_ON;
						end else begin
							nxt.mode  = MODE_ALARM;
							nxt.alarm = 1'b1;
						end
					end
				end
			end
			OP_FORCE: begin
				if (item.force_on) begin
					nxt.mode = MODE_FORCE;
				end else begin
					nxt.timer_running = 1'b0;
					nxt.timer_left    = '0;
					nxt.mode          = MODE_ON;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule : topc_next

`default_nettype wire

// ===== design/top_off_pump_controller_unit.sv =====
// Top level of the top-off pump controller: input register, state, result register.
//
// Channel  Signals                         Direction  Payload
// in       in_valid, in_ready, in_data     input      in_item_t (poll, tick or force)
// out      out_valid, out_ready, out_data  output     out_item_t (relays, alarm, mode)
// cfg      cfg_valid, cfg_ready, cfg_data  input      run timeout in ticks, 16 bits
//
// Each transaction passes through the input register and then the result register;
// one transaction can enter per cycle while the result register is not stalled.
// The state update is a single pass through the next-state logic when a transaction
// moves from the input register to the result register.
// A stalled result holds the result register; the input register still takes one more
// transaction, after which in_ready drops until the result is taken.
// Reset returns the mode to on, clears relays, alarm and timer, and sets the timeout to 60.
`default_nettype none

module top_off_pump_controller_unit
	import topc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TimerW-1:0] cfg_data
);

	logic [TimerW-1:0] timeout_q;
	ctrl_state_t       state_q;
	ctrl_state_t       state_next;
	in_item_t          item_s1;
	logic              valid_s1;
	out_item_t         res_s2;
	logic              valid_s2;
	logic              advance_s2;

	// Handshake: the result register frees up when empty or when its result is taken.
	assign advance_s2 = !valid_s2 || out_ready;
	assign in_ready   = !valid_s1 || advance_s2;
	assign cfg_ready  = 1'b1;
	assign out_valid  = valid_s2;
	assign out_data   = res_s2;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Next-state logic for the transaction in the input register.
	topc_next u_next (
		.cur     (state_q),
		.item    (item_s1),
		.timeout (timeout_q),
		.nxt     (state_next)
	);

	// Controller state, updated as a transaction moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_ON, timer_left: '0, timer_running: 1'b0,
				fill_pump: 1'b0, refill_valve: 1'b0, alarm: 1'b0};
		end else if (valid_s1 && advance_s2) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s2) begin
			res_s2.tank_pump_on     <= state_next.fill_pump;
			res_s2.reserve_valve_on <= state_next.refill_valve;
			res_s2.alarm            <= state_next.alarm;
			res_s2.mode             <= state_next.mode;
		end
	end

endmodule : top_off_pump_controller_unit

`default_nettype wire
